FILE: src/sfdc_pkg.sv
package sfdc_pkg;

    localparam int unsigned ENTRIES = 64;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned CNT_W   = IDX_W + 1;

    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_ANTI     = 2'd1;
    localparam logic [1:0] OP_ACTIVATE = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_LOGSTATS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_UPDATE,
        S_ACT_CLEAR,
        S_ACT_SCAN,
        S_ACT_MUL,
        S_ACT_CMP,
        S_ACT_PICK,
        S_ACT_ADMIT,
        S_DONE
    } state_t;

endpackage

FILE: src/static_frequency_density_cache_unit.sv
// One item is taken at a time and gives one result beat. A request or
// anti-request sweeps the slot memory one entry a cycle. Activation runs
// up to ENTRIES selection rounds, each sweeping all entries through one
// 32x32 multiplier pair in states S_ACT_SCAN, S_ACT_MUL and S_ACT_CMP; it
// ends early once a round finds no candidate. The single read port of the
// slot memory makes each sweep visit one entry at a time. A new input is
// taken only once the previous result beat has left the output register.
module static_frequency_density_cache_unit
    import sfdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] object_id,
    input  logic [31:0] object_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [1:0]  status,
    output logic [63:0] hit_count,
    output logic [63:0] hit_bytes,
    output logic [39:0] filled_bytes
);

    logic [63:0] mem_id   [ENTRIES];
    logic [31:0] mem_req  [ENTRIES];
    logic [31:0] mem_size [ENTRIES];

    logic [ENTRIES-1:0] valid_reg, cached_reg, done_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0] rd_addr;
    logic [63:0] rd_id;
    logic [31:0] rd_req, rd_size;
    logic [IDX_W-1:0] rd_idx_reg;

    logic [1:0]  op_reg;
    logic [63:0] id_reg;
    logic [31:0] size_reg;

    logic found_reg, found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] keep_size_reg, keep_size_next;

    logic best_ok_reg, best_ok_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [31:0] best_req_reg, best_req_next;
    logic [31:0] best_size_reg, best_size_next;
    logic [31:0] cand_req_reg, cand_size_reg;
    logic [IDX_W-1:0] cand_idx_reg;
    logic cand_ok_reg;
    logic [63:0] lhs_reg, rhs_reg;

    logic [39:0] capacity_reg;
    logic        logstats_reg;
    logic [63:0] hits_reg, hits_next;
    logic [63:0] hbytes_reg, hbytes_next;
    logic [39:0] admit_reg, admit_next;

    logic        we;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0] wr_id;
    logic [31:0] wr_req, wr_size;

    logic        out_valid_reg;
    logic        hit_reg, hit_next;
    logic [1:0]  status_reg, status_next;
    logic        emit;
    logic        set_valid, clr_cached_all, set_cached, mark_done, clr_done;
    logic [IDX_W-1:0] free_idx;
    logic        free_ok;
    logic [40:0] admit_sum;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign status = status_reg;
    assign hit_count = hits_reg;
    assign hit_bytes = hbytes_reg;
    assign filled_bytes = admit_reg;

    always_comb
    begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_ok = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign admit_sum = {1'b0, admit_reg} + {9'd0, best_size_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_id[wr_addr]   <= wr_id;
            mem_req[wr_addr]  <= wr_req;
            mem_size[wr_addr] <= wr_size;
        end
        rd_id      <= mem_id[rd_addr];
        rd_req     <= mem_req[rd_addr];
        rd_size    <= mem_size[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        round_next = round_reg;
        rd_addr = ptr_reg[IDX_W-1:0];
        found_next = found_reg;
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        keep_size_next = keep_size_reg;
        best_ok_next = best_ok_reg;
        best_next = best_reg;
        best_req_next = best_req_reg;
        best_size_next = best_size_reg;
        hits_next = hits_reg;
        hbytes_next = hbytes_reg;
        admit_next = admit_reg;
        hit_next = hit_reg;
        status_next = status_reg;
        we = 1'b0;
        wr_addr = slot_reg;
        wr_id = id_reg;
        wr_req = cnt_reg;
        wr_size = keep_size_reg;
        emit = 1'b0;
        set_valid = 1'b0;
        clr_cached_all = 1'b0;
        set_cached = 1'b0;
        mark_done = 1'b0;
        clr_done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                rd_addr = '0;
                found_next = 1'b0;
                if (in_valid && in_ready)
                begin
                    case (op)
                        OP_REQUEST, OP_ANTI: state_next = S_SCAN;
                        OP_ACTIVATE: state_next = S_ACT_CLEAR;
                        default:
                        begin
                            hits_next = '0;
                            hbytes_next = '0;
                            hit_next = 1'b0;
                            status_next = ST_OK;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // data for entry ptr-1 is on the read port
            S_SCAN:
            begin
                if (ptr_reg != '0 && !found_reg && valid_reg[rd_idx_reg]
                    && rd_id == id_reg)
                begin
                    found_next = 1'b1;
                    slot_next = rd_idx_reg;
                    cnt_next = rd_req;
                    keep_size_next = rd_size;
                end
                ptr_next = ptr_reg + CNT_W'(1);
                if (ptr_reg == CNT_W'(ENTRIES - 1))
                    state_next = S_SCAN_LAST;
            end
            S_SCAN_LAST:
            begin
                if (!found_reg && valid_reg[rd_idx_reg] && rd_id == id_reg)
                begin
                    found_next = 1'b1;
                    slot_next = rd_idx_reg;
                    cnt_next = rd_req;
                    keep_size_next = rd_size;
                end
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                hit_next = 1'b0;
                status_next = ST_OK;
                if (op_reg == OP_REQUEST)
                begin
                    if (found_reg)
                    begin
                        we = 1'b1;
                        wr_id = id_reg;
                        wr_req = (cnt_reg == '1) ? cnt_reg : cnt_reg + 32'd1;
                        wr_size = keep_size_reg;
                        if (cached_reg[slot_reg])
                        begin
                            hit_next = 1'b1;
                            if (logstats_reg)
                            begin
                                hits_next = hits_reg + 64'd1;
                                hbytes_next = hbytes_reg + {32'd0, size_reg};
                            end
                        end
                    end
                    else if (free_ok)
                    begin
                        we = 1'b1;
                        wr_addr = free_idx;
                        wr_req = 32'd1;
                        wr_size = (size_reg == '0) ? 32'd1 : size_reg;
                        set_valid = 1'b1;
                    end
                    else
                        status_next = ST_FULL;
                end
                else
                begin
                    if (found_reg && cnt_reg != '0)
                    begin
                        we = 1'b1;
                        wr_req = cnt_reg - 32'd1;
                    end
                    else
                        status_next = ST_BAD;
                end
                state_next = S_DONE;
            end
            S_ACT_CLEAR:
            begin
                clr_cached_all = 1'b1;
                clr_done = 1'b1;
                admit_next = '0;
                round_next = '0;
                ptr_next = '0;
                best_ok_next = 1'b0;
                state_next = S_ACT_SCAN;
            end
            // issue read of entry ptr
            S_ACT_SCAN:
            begin
                rd_addr = ptr_reg[IDX_W-1:0];
                state_next = S_ACT_MUL;
            end
            S_ACT_MUL:
                state_next = S_ACT_CMP;
            S_ACT_CMP:
            begin
                if (cand_ok_reg && (!best_ok_reg || lhs_reg > rhs_reg))
                begin
                    best_ok_next = 1'b1;
                    best_next = cand_idx_reg;
                    best_req_next = cand_req_reg;
                    best_size_next = cand_size_reg;
                end
                ptr_next = ptr_reg + CNT_W'(1);
                if (ptr_reg == CNT_W'(ENTRIES - 1))
                    state_next = S_ACT_PICK;
                else
                    state_next = S_ACT_SCAN;
            end
            S_ACT_PICK:
            begin
                if (!best_ok_reg)
                begin
                    hit_next = 1'b0;
                    status_next = ST_OK;
                    state_next = S_DONE;
                end
                else
                    state_next = S_ACT_ADMIT;
            end
            S_ACT_ADMIT:
            begin
                mark_done = 1'b1;
                if (admit_sum <= {1'b0, capacity_reg})
                begin
                    admit_next = admit_sum[39:0];
                    set_cached = 1'b1;
                end
                round_next = round_reg + CNT_W'(1);
                ptr_next = '0;
                best_ok_next = 1'b0;
                if (round_reg == CNT_W'(ENTRIES - 1))
                begin
                    hit_next = 1'b0;
                    status_next = ST_OK;
                    state_next = S_DONE;
                end
                else
                    state_next = S_ACT_SCAN;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= op;
            id_reg <= object_id;
            size_reg <= object_size;
        end
        found_reg <= found_next;
        slot_reg <= slot_next;
        cnt_reg <= cnt_next;
        keep_size_reg <= keep_size_next;
        best_reg <= best_next;
        best_req_reg <= best_req_next;
        best_size_reg <= best_size_next;
        cand_req_reg <= rd_req;
        cand_size_reg <= rd_size;
        cand_idx_reg <= rd_idx_reg;
        if (state_reg == S_ACT_MUL)
        begin
            lhs_reg <= {32'd0, rd_req} * {32'd0, best_size_reg};
            rhs_reg <= {32'd0, best_req_reg} * {32'd0, rd_size};
            cand_ok_reg <= valid_reg[rd_idx_reg] && !done_reg[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            round_reg <= '0;
            best_ok_reg <= 1'b0;
            valid_reg <= '0;
            cached_reg <= '0;
            done_reg <= '0;
            capacity_reg <= '0;
            logstats_reg <= 1'b0;
            hits_reg <= '0;
            hbytes_reg <= '0;
            admit_reg <= '0;
            out_valid_reg <= 1'b0;
            hit_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            round_reg <= round_next;
            best_ok_reg <= best_ok_next;
            hits_reg <= hits_next;
            hbytes_reg <= hbytes_next;
            admit_reg <= admit_next;
            hit_reg <= hit_next;
            status_reg <= status_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CAPACITY: capacity_reg <= cfg_data;
                    REG_LOGSTATS: logstats_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (set_valid)
                valid_reg[free_idx] <= 1'b1;
            if (clr_cached_all)
                cached_reg <= '0;
            else if (set_valid)
                cached_reg[free_idx] <= 1'b0;
            else if (set_cached)
                cached_reg[best_reg] <= 1'b1;
            if (clr_done)
                done_reg <= '0;
            else if (mark_done)
                done_reg[best_reg] <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        set_valid |-> !valid_reg[free_idx])
        else $error("allocation over a live slot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == ST_FULL) |-> !hit_reg)
        else $error("hit reported on full table");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cached_reg & ~valid_reg) == '0)
        else $error("cached mark on empty slot");

endmodule
